>>> sv/fdmm_pkg.sv
// ----------------------------------------------------------------------------
// fdmm_pkg: shared definitions of the frame difference motion meter
// Sizes, scale constants, controller states and control/status groups.
// ----------------------------------------------------------------------------
package fdmm_pkg;

    localparam int SAMPLE_STRIDE = 12;
    localparam int MAX_SAMPLES   = 32768;
    localparam int MOTION_MAX    = 100000;

    localparam int PX_W     = 8;
    localparam int POS_W    = 19;
    localparam int SUM_W    = 24;
    localparam int Q_W      = $clog2(MOTION_MAX + 1);
    localparam int PH_W     = (SAMPLE_STRIDE > 1) ? $clog2(SAMPLE_STRIDE) : 1;
    localparam int ADDR_W   = $clog2(MAX_SAMPLES);
    localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);

    // motion = sum * NUM_SCALE / (len << DEN_SHIFT)
    localparam int NUM_SCALE = MOTION_MAX * SAMPLE_STRIDE;
    localparam int SCALE_W   = $clog2(NUM_SCALE + 1);
    localparam int NUM_W     = SUM_W + SCALE_W;
    localparam int DEN_SHIFT = 6;
    localparam int DEN_W     = POS_W + DEN_SHIFT;
    localparam int REM_W     = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;
    localparam int STEP_W    = $clog2(Q_W);

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef enum logic [2:0] {
        ST_RUN,
        ST_DRAIN,
        ST_MUL,
        ST_CHK,
        ST_DIV,
        ST_OUT
    } fdmm_state_t;

    typedef struct packed {
        logic accept;
        logic clr_q;
        logic mul;
        logic chk;
        logic div_step;
    } fdmm_cmd_t;

    typedef struct packed {
        logic compared;
        logic quot_big;
        logic div_last;
    } fdmm_status_t;

endpackage

>>> sv/fdmm_in_if.sv
// ----------------------------------------------------------------------------
// fdmm_in_if: frame byte channel
// Valid/ready channel carrying one frame byte and its end-of-frame flag.
// ----------------------------------------------------------------------------
interface fdmm_in_if import fdmm_pkg::*;;
    logic            valid;
    logic            ready;
    logic [PX_W-1:0] pixel_byte;
    logic            frame_end;

    modport source (output valid, output pixel_byte, output frame_end, input ready);
    modport sink   (input valid, input pixel_byte, input frame_end, output ready);
endinterface

>>> sv/fdmm_out_if.sv
// ----------------------------------------------------------------------------
// fdmm_out_if: motion result channel
// Valid/ready channel carrying one per-frame motion result.
// ----------------------------------------------------------------------------
interface fdmm_out_if import fdmm_pkg::*;;
    logic           valid;
    logic           ready;
    logic [Q_W-1:0] motion_level;
    logic           compared;
    logic           too_long;

    modport source (output valid, output motion_level, output compared,
                    output too_long, input ready);
    modport sink   (input valid, input motion_level, input compared,
                    input too_long, output ready);
endinterface

>>> sv/frame_difference_motion_meter_unit.sv
// ----------------------------------------------------------------------------
// frame_difference_motion_meter_unit: per-frame motion level from byte stream
// Sums sampled byte differences against the previous frame and scales them.
// ----------------------------------------------------------------------------
// Usage:
//   pixels carries one RGB byte per transaction, frame_end high on the last
//   byte. Every SAMPLE_STRIDE-th byte is checked against the reference
//   memory and written back. Mid-frame bytes are taken one per cycle; the
//   sample path is a memory read stage followed by a difference/write stage.
//   results carries one transaction per frame: motion_level, compared and
//   too_long.
//   After the last byte's transaction the sample path drains; a baseline or
//   overlong frame then goes straight to its result, while a compared frame
//   is scaled, checked for saturation and, unless the quotient saturates,
//   divided by the restoring divider, which retires one quotient bit a cycle.
//   No byte is taken from the last byte of a frame until its result
//   transaction completes.
//   Reset clears the counters, the sum and the reference flag, so the first
//   frame is a baseline; the reference memory itself is not cleared.
//   A stalled receiver holds the result and the byte channel stays closed.
// ----------------------------------------------------------------------------
module frame_difference_motion_meter_unit import fdmm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    fdmm_in_if.sink     pixels,
    fdmm_out_if.source  results
);

    fdmm_cmd_t    cmd;
    fdmm_status_t status;

    // Sequence streaming, then the end-of-frame arithmetic.
    fdmm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixels.valid),
        .frame_end (pixels.frame_end),
        .out_ready (results.ready),
        .status    (status),
        .in_ready  (pixels.ready),
        .out_valid (results.valid),
        .cmd       (cmd)
    );

    // Hold the reference samples, the running sum and the divider.
    fdmm_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .pixel_byte   (pixels.pixel_byte),
        .frame_end    (pixels.frame_end),
        .status       (status),
        .motion_level (results.motion_level),
        .compared     (results.compared),
        .too_long     (results.too_long)
    );

endmodule

>>> sv/fdmm_ctrl.sv
// ----------------------------------------------------------------------------
// fdmm_ctrl: sequencer of the motion meter
// Streams bytes, then steps the end-of-frame multiply, check and divide.
// ----------------------------------------------------------------------------
module fdmm_ctrl import fdmm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         frame_end,
    input  logic         out_ready,
    input  fdmm_status_t status,
    output logic         in_ready,
    output logic         out_valid,
    output fdmm_cmd_t    cmd
);

    fdmm_state_t state_reg;
    fdmm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (in_valid && frame_end)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = status.compared ? ST_MUL : ST_OUT;
            ST_MUL:   state_next = ST_CHK;
            ST_CHK:   state_next = status.quot_big ? ST_OUT : ST_DIV;
            ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_RUN;
                end
            end
            default:  state_next = ST_RUN;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            ST_RUN:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_DRAIN: cmd.clr_q    = 1'b1;
            ST_MUL:   cmd.mul      = 1'b1;
            ST_CHK:   cmd.chk      = 1'b1;
            ST_DIV:   cmd.div_step = 1'b1;
            ST_OUT:   out_valid    = 1'b1;
            default:  in_ready     = 1'b0;
        endcase
    end

endmodule

>>> sv/fdmm_datapath.sv
// ----------------------------------------------------------------------------
// fdmm_datapath: sample store, difference sum and restoring divider
// Two-stage sample path into the reference memory, then scale and divide.
// ----------------------------------------------------------------------------
module fdmm_datapath import fdmm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  fdmm_cmd_t       cmd,
    input  logic [PX_W-1:0] pixel_byte,
    input  logic            frame_end,
    output fdmm_status_t    status,
    output logic [Q_W-1:0]  motion_level,
    output logic            compared,
    output logic            too_long
);

    logic [PX_W-1:0] ref_mem [MAX_SAMPLES];

    // byte counting and frame state
    logic [PH_W-1:0]   phase_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic              ovf_reg;
    logic              ref_valid_reg;
    logic [POS_W-1:0]  ref_len_reg;
    logic              compared_reg;
    logic              too_long_reg;
    logic [POS_W-1:0]  fin_len_reg;

    // sample stage
    logic              s1_sample_reg;
    logic              s1_last_reg;
    logic [PX_W-1:0]   s1_px_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [PX_W-1:0]   rd_data_reg;

    // sum and divide
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_fin_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  dsr_reg;
    logic [STEP_W-1:0] step_reg;
    logic [Q_W-1:0]    q_reg;

    logic              sample;
    logic              in_store;
    logic              ovf_next;
    logic [POS_W-1:0]  len;
    logic [PX_W-1:0]   diff;
    logic [SUM_W:0]    sum_wide;
    logic [SUM_W-1:0]  sum_next;
    logic [DEN_W-1:0]  den;
    logic              rem_ge;

    assign sample   = !ovf_reg && (phase_reg == '0);
    assign in_store = idx_reg < CNT_W'(MAX_SAMPLES);
    assign ovf_next = ovf_reg || (sample && !in_store) || (pos_reg == POS_MAX);
    assign len      = pos_reg + POS_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            pos_reg       <= '0;
            idx_reg       <= '0;
            ovf_reg       <= 1'b0;
            ref_valid_reg <= 1'b0;
            ref_len_reg   <= '0;
            s1_sample_reg <= 1'b0;
            s1_last_reg   <= 1'b0;
        end
        else
        begin
            s1_sample_reg <= cmd.accept && sample && in_store;
            s1_last_reg   <= cmd.accept && frame_end;
            if (cmd.accept)
            begin
                if (frame_end)
                begin
                    phase_reg     <= '0;
                    pos_reg       <= '0;
                    idx_reg       <= '0;
                    ovf_reg       <= 1'b0;
                    ref_valid_reg <= !ovf_next;
                    ref_len_reg   <= ovf_next ? '0 : len;
                end
                else
                begin
                    phase_reg <= (phase_reg == PH_W'(SAMPLE_STRIDE - 1)) ? '0
                                                                         : phase_reg + PH_W'(1);
                    if (pos_reg != POS_MAX)
                    begin
                        pos_reg <= len;
                    end
                    if (sample && in_store)
                    begin
                        idx_reg <= idx_reg + CNT_W'(1);
                    end
                    ovf_reg <= ovf_next;
                end
            end
        end
    end

    // Latch the frame verdict before the reference fields move on.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && frame_end)
        begin
            compared_reg <= !ovf_next && ref_valid_reg && (ref_len_reg == len);
            too_long_reg <= ovf_next;
            fin_len_reg  <= len;
        end
        if (cmd.accept)
        begin
            s1_px_reg   <= pixel_byte;
            s1_addr_reg <= idx_reg[ADDR_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && sample && in_store)
        begin
            rd_data_reg <= ref_mem[idx_reg[ADDR_W-1:0]];
        end
        if (s1_sample_reg)
        begin
            ref_mem[s1_addr_reg] <= s1_px_reg;
        end
    end

    assign diff     = (s1_px_reg > rd_data_reg) ? s1_px_reg - rd_data_reg
                                                : rd_data_reg - s1_px_reg;
    assign sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(diff);

    always_comb
    begin
        sum_next = sum_reg;
        if (s1_sample_reg)
        begin
            sum_next = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= s1_last_reg ? '0 : sum_next;
        end
    end

    assign den    = {fin_len_reg, {DEN_SHIFT{1'b0}}};
    assign rem_ge = rem_reg >= dsr_reg;

    always_ff @(posedge clk)
    begin
        if (s1_last_reg)
        begin
            sum_fin_reg <= sum_next;
        end
        if (cmd.mul)
        begin
            num_reg <= NUM_W'(sum_fin_reg) * NUM_W'(NUM_SCALE);
        end
        if (cmd.clr_q)
        begin
            q_reg <= '0;
        end
        else if (cmd.chk)
        begin
            if (status.quot_big)
            begin
                q_reg <= Q_W'(MOTION_MAX);
            end
            rem_reg  <= REM_W'(num_reg);
            dsr_reg  <= REM_W'(den) << (Q_W - 1);
            step_reg <= STEP_W'(Q_W - 1);
        end
        else if (cmd.div_step)
        begin
            if (rem_ge)
            begin
                rem_reg <= rem_reg - dsr_reg;
            end
            q_reg    <= {q_reg[Q_W-2:0], rem_ge};
            dsr_reg  <= dsr_reg >> 1;
            step_reg <= step_reg - STEP_W'(1);
        end
    end

    assign status.compared = compared_reg;
    assign status.quot_big = REM_W'(num_reg) >= (REM_W'(den) << Q_W);
    assign status.div_last = (step_reg == '0);

    assign motion_level = (q_reg > Q_W'(MOTION_MAX)) ? Q_W'(MOTION_MAX) : q_reg;
    assign compared     = compared_reg;
    assign too_long     = too_long_reg;

endmodule

>>> dv/frame_difference_motion_meter_unit_tb.sv
// ----------------------------------------------------------------------------
// frame_difference_motion_meter_unit_tb: self-checking bench of the motion meter
// Streams RGB frames byte by byte, predicts each per-frame result in a
// scoreboard and compares every result transaction field by field.
// ----------------------------------------------------------------------------
module frame_difference_motion_meter_unit_tb;
    import fdmm_pkg::*;

    localparam int          TOO_LONG_LEN = SAMPLE_STRIDE * MAX_SAMPLES + 1;
    localparam int          RANDOM_BYTES = 1500;
    localparam int          DRAIN_CYCLES = 4 + Q_W + 8;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          IDLE_PCT     = 13;
    localparam longint      CYCLE_LIMIT  = 2_000_000;

    typedef struct packed {
        logic [Q_W-1:0] motion_level;
        logic           compared;
        logic           too_long;
    } motion_result_t;

    // How the bytes of a frame are chosen.
    typedef enum int {
        FILL_CONST,     // every byte equals the argument
        FILL_NOISE,     // every byte random
        FILL_DRIFT      // sampled bytes move from the last frame by up to +/- arg
    } fill_mode_t;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the sampled reference frame, the running difference
    // sum and the overflow state, and queues the result each frame must give.
    // ------------------------------------------------------------------------
    class motion_scoreboard;
        logic [7:0]       ref_bytes [MAX_SAMPLES];
        logic [POS_W-1:0] ref_len;
        bit               have_ref;
        logic [POS_W-1:0] pos;
        logic [SUM_W-1:0] diff_sum;
        bit               spilled;
        motion_result_t   pending_results[$];
        int               mismatches;
        int               results_seen;

        function new();
            ref_len      = '0;
            have_ref     = 1'b0;
            pos          = '0;
            diff_sum     = '0;
            spilled      = 1'b0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        // Advance the prediction by one accepted byte.
        function void note_byte(logic [7:0] px, logic last);
            int unsigned       idx;
            int unsigned       len;
            logic [7:0]        old;
            logic [7:0]        delta;
            longint unsigned   quot;
            motion_result_t    r;
            if (!spilled && (pos % SAMPLE_STRIDE) == 0)
            begin
                idx = pos / SAMPLE_STRIDE;
                if (idx < MAX_SAMPLES)
                begin
                    old   = ref_bytes[idx];
                    delta = (px > old) ? px - old : old - px;
                    if (diff_sum > SUM_MAX - SUM_W'(delta))
                        diff_sum = SUM_MAX;
                    else
                        diff_sum = diff_sum + SUM_W'(delta);
                    ref_bytes[idx] = px;
                end
                else
                    spilled = 1'b1;
            end
            len = 32'(pos) + 1;
            if (pos == POS_MAX)
                spilled = 1'b1;
            else
                pos = pos + 1'b1;
            if (!last)
                return;

            r = '0;
            if (spilled)
            begin
                r.too_long = 1'b1;
                have_ref   = 1'b0;
                ref_len    = '0;
            end
            else
            begin
                if (have_ref && 32'(ref_len) == len)
                begin
                    quot = (longint'(diff_sum) * MOTION_MAX * SAMPLE_STRIDE)
                           / (longint'(len) << DEN_SHIFT);
                    if (quot > MOTION_MAX)
                        quot = MOTION_MAX;
                    r.motion_level = quot[Q_W-1:0];
                    r.compared     = 1'b1;
                end
                have_ref = 1'b1;
                ref_len  = len[POS_W-1:0];
            end
            pending_results.push_back(r);
            pos      = '0;
            diff_sum = '0;
            spilled  = 1'b0;
        endfunction

        task report(string msg);
            $display("MISMATCH result %0d: %s", results_seen, msg);
            mismatches++;
        endtask

        // Compare one result transaction with the oldest prediction.
        task check_result(motion_result_t got);
            motion_result_t want;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report($sformatf("unexpected result level=%0d compared=%0b too_long=%0b",
                                 got.motion_level, got.compared, got.too_long));
                return;
            end
            want = pending_results.pop_front();
            if (got.motion_level !== want.motion_level)
                report($sformatf("motion_level %0d, want %0d",
                                 got.motion_level, want.motion_level));
            if (got.compared !== want.compared)
                report($sformatf("compared %0b, want %0b", got.compared, want.compared));
            if (got.too_long !== want.too_long)
                report($sformatf("too_long %0b, want %0b", got.too_long, want.too_long));
        endtask
    endclass

    logic clk;
    logic rst_n;

    fdmm_in_if  pixels_if ();
    fdmm_out_if results_if ();

    frame_difference_motion_meter_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pixels_if),
        .results (results_if)
    );

    motion_scoreboard scoreboard = new();

    // Stimulus shaping flags: steady turns idling off on both sides, hold_req
    // starts the long receiver hold-off, holding is high while it lasts.
    bit     steady   = 1'b0;
    bit     hold_req = 1'b0;
    bit     holding  = 1'b0;
    longint cycles   = 0;
    int     bytes_sent = 0;

    // Sampled bytes of the last frame sent, so drifting frames stay close to it.
    logic [7:0] last_samples [MAX_SAMPLES];

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result sink: random back-pressure, none in steady stretches, and a solid
    // stall while the hold-off runs.
    always @(posedge clk)
    begin
        if (holding)
            results_if.ready <= 1'b0;
        else if (steady)
            results_if.ready <= 1'b1;
        else
            results_if.ready <= ($urandom_range(99) >= IDLE_PCT);
    end

    // Hold off the receiver for a fixed stretch, counted here, while the
    // sender keeps offering bytes, so the block backs up and closes its input.
    initial
    begin
        wait (hold_req);
        @(posedge clk);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding <= 1'b0;
    end

    // Result monitor: every completed result transaction goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && results_if.valid && results_if.ready)
            scoreboard.check_result('{motion_level: results_if.motion_level,
                                      compared:     results_if.compared,
                                      too_long:     results_if.too_long});
    end

    // Offer one byte, with random idle cycles in front, and hold it until the
    // transaction completes. Valid stays high for a following byte.
    task automatic push_byte(input logic [7:0] b, input logic last);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            pixels_if.valid <= 1'b0;
            @(posedge clk);
        end
        pixels_if.valid      <= 1'b1;
        pixels_if.pixel_byte <= b;
        pixels_if.frame_end  <= last;
        do
            @(posedge clk);
        while (!pixels_if.ready);
        scoreboard.note_byte(b, last);
        bytes_sent++;
    endtask

    // Send a whole frame of len bytes; sampled bytes are remembered so the
    // next drifting frame can stay near them.
    task automatic send_frame(input int unsigned len, input fill_mode_t mode,
                              input int unsigned arg);
        logic [7:0]  b;
        int unsigned idx;
        int          v;
        for (int unsigned p = 0; p < len; p++)
        begin
            if (mode == FILL_CONST)
                b = arg[7:0];
            else
                b = 8'($urandom_range(255));
            if (p % SAMPLE_STRIDE == 0 && p / SAMPLE_STRIDE < MAX_SAMPLES)
            begin
                idx = p / SAMPLE_STRIDE;
                if (mode == FILL_DRIFT)
                begin
                    v = int'(last_samples[idx]) + int'($urandom_range(2 * arg)) - int'(arg);
                    if (v < 0)
                        v = 0;
                    if (v > 255)
                        v = 255;
                    b = v[7:0];
                end
                last_samples[idx] = b;
            end
            push_byte(b, p == len - 1);
        end
    endtask

    // Drop valid and wait until every predicted result has been taken.
    task automatic drain_results();
        pixels_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (scoreboard.pending_results.size() != 0);
    endtask

    initial
    begin
        int unsigned spreads [7] = '{0, 1, 2, 5, 20, 60, 128};
        int unsigned len;
        int unsigned frames;
        int unsigned pick;
        int          scene;
        int          random_start;

        pixels_if.valid      = 1'b0;
        pixels_if.pixel_byte = '0;
        pixels_if.frame_end  = 1'b0;
        results_if.ready     = 1'b0;
        rst_n                = 1'b0;
        for (int i = 0; i < MAX_SAMPLES; i++)
            last_samples[i] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: first frame after reset is a baseline.
        send_frame(1, FILL_CONST, 0);
        // Single-byte frame jumping 0 -> 255: motion saturates.
        send_frame(1, FILL_CONST, 255);
        // Identical frame: compared, zero motion.
        send_frame(1, FILL_CONST, 255);
        // Length change forces a new baseline.
        send_frame(2, FILL_CONST, 0);
        send_frame(2, FILL_NOISE, 0);
        // Two samples per frame, small moves stay under saturation.
        send_frame(13, FILL_CONST, 128);
        send_frame(13, FILL_DRIFT, 2);
        send_frame(13, FILL_DRIFT, 0);
        // One sample beyond the store: flagged too long, reference cleared.
        send_frame(TOO_LONG_LEN, FILL_NOISE, 0);
        // Same length as before the overflow, still a baseline now.
        send_frame(13, FILL_CONST, 128);
        send_frame(13, FILL_DRIFT, 1);

        // Random: scenes of same-length frames that drift from one another,
        // with noisy frames and occasional off-by-a-few lengths mixed in.
        random_start = bytes_sent;
        scene        = 0;
        while (bytes_sent - random_start < RANDOM_BYTES)
        begin
            if (scene == 2)
                hold_req = 1'b1;
            if (scene == 3)
                drain_results();
            steady = (scene >= 5 && scene < 9);

            pick = $urandom_range(99);
            if (pick < 85)
                len = $urandom_range(20, 1);
            else if (pick < 98)
                len = $urandom_range(100, 21);
            else
                len = $urandom_range(400, 101);
            frames = $urandom_range(6, 2);

            send_frame(len, FILL_NOISE, 0);
            for (int unsigned k = 1; k < frames; k++)
            begin
                pick = $urandom_range(99);
                if (pick < 75)
                    send_frame(len, FILL_DRIFT, spreads[$urandom_range(6)]);
                else if (pick < 88)
                    send_frame(len, FILL_NOISE, 0);
                else if (len > 1 && $urandom_range(1) == 1)
                    send_frame(len - 1, FILL_NOISE, 0);
                else
                    send_frame(len + $urandom_range(3, 1), FILL_NOISE, 0);
            end
            scene++;
        end
        steady = 1'b0;

        // Wait out the last results, then give the block its tail latency.
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (scoreboard.mismatches == 0 && scoreboard.pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> frame_difference_motion_meter_unit.f
sv/fdmm_pkg.sv
sv/fdmm_in_if.sv
sv/fdmm_out_if.sv
sv/fdmm_ctrl.sv
sv/fdmm_datapath.sv
sv/frame_difference_motion_meter_unit.sv
dv/frame_difference_motion_meter_unit_tb.sv
